// ===== hw/rtl/axnorm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axnorm_pkg: shared types and constants of the axis normalizer
// widths, item and divider structs, register codes, dead zone reciprocal
// ----------------------------------------------------------------------------
package axnorm_pkg;

    localparam int CHANNELS    = 3;
    localparam int SAMPLE_BITS = 12;
    localparam int WINDOW_DEF  = 10;
    localparam int LEVEL_TOP   = 127;
    localparam int LEVEL_W     = 8;
    localparam int CFG_W       = 12;
    localparam int RESET_LOW   = 800;
    localparam int RESET_HIGH  = 3600;
    localparam int QUEUE_DEPTH = 2;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // register map
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam int PDATA_W   = 32;
    localparam logic [REG_IDX_W-1:0] REG_LOW  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH = 1'b1;

    // dead zone: span / 10 as multiply by rounded-up reciprocal, exact for the sample width
    localparam int DEAD_DIV  = 10;
    localparam int DZ_SHIFT  = SAMPLE_BITS + 4;
    localparam int DZ_MUL_W  = DZ_SHIFT - 3;
    localparam int DZ_MUL    = ((1 << DZ_SHIFT) + DEAD_DIV - 1) / DEAD_DIV;
    localparam int DZ_PROD_W = SAMPLE_BITS + DZ_MUL_W;

    // shared divider: quotient always below 256, numerator covers span * 254
    localparam int QUO_W     = LEVEL_W;
    localparam int DIV_NUM_W = SAMPLE_BITS + LEVEL_W;
    localparam int STEP_W    = $clog2(QUO_W);

    typedef logic [SAMPLE_BITS-1:0]    t_sample;
    typedef logic signed [LEVEL_W-1:0] t_level;

    typedef struct packed {
        t_sample [CHANNELS-1:0] samples;
        logic                   last;
    } t_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        t_sample              den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             low_we;
        logic             high_we;
        logic [CFG_W-1:0] value;
    } t_cfg_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/autocal_axis_normalize_average.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// autocal_axis_normalize_average: self-calibrating three-channel axis normalizer
// tracks per-channel travel, maps readings to +127..-127, reports window averages
// ----------------------------------------------------------------------------
// Each accepted item is one sampling tick with a 12-bit reading per channel.
// Every channel keeps its lowest and highest reading, trims a dead zone of one
// tenth of that span at both ends, clamps the reading into the remaining band
// and maps it inverted onto +127 (band bottom) .. -127 (band top), or 0 when
// the band is empty. Mapped values are summed, and after WINDOW ticks one
// result item carries each sum divided by WINDOW (truncated toward zero).
// Each tick passes through the back end one channel after another: calibration,
// band, clamp and the shared eight-step divider; a channel with an empty band
// skips the divider. The tick that closes a window then forms the averages by
// reciprocal multiplication, channel by channel, and loads the result register.
// A two-deep item queue lets the input side run ahead, and the result register
// lets the back end continue while a result waits. Writing initial_low (byte
// address 0) or initial_high (address 4) reloads the seen minimum or maximum of
// every channel; write only while idle.
// ----------------------------------------------------------------------------
module autocal_axis_normalize_average #(
    parameter int WINDOW = axnorm_pkg::WINDOW_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // sample items
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire [axnorm_pkg::SAMPLE_BITS-1:0]    i_sample_a,
    input  wire [axnorm_pkg::SAMPLE_BITS-1:0]    i_sample_b,
    input  wire [axnorm_pkg::SAMPLE_BITS-1:0]    i_sample_c,
    // result items
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [axnorm_pkg::LEVEL_W-1:0] o_level_a,
    output logic signed [axnorm_pkg::LEVEL_W-1:0] o_level_b,
    output logic signed [axnorm_pkg::LEVEL_W-1:0] o_level_c,
    // register port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [axnorm_pkg::PADDR_W-1:0]        paddr,
    input  wire [axnorm_pkg::PDATA_W-1:0]        pwdata,
    output logic [axnorm_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready
);
    import axnorm_pkg::*;

    logic [CFG_W-1:0]                 r_initial_low;
    logic [CFG_W-1:0]                 r_initial_high;
    logic [REG_IDX_W-1:0]             n_reg_idx;
    logic                             n_wr;
    t_cfg_wr                          w_cfg;
    t_sample [CHANNELS-1:0]           w_samples;
    t_item                            w_item;
    logic                             w_item_valid;
    logic                             w_item_pop;
    t_div_req                         w_div_req;
    t_div_rsp                         w_div_rsp;
    logic [CHANNELS-1:0][LEVEL_W-1:0] w_levels;

    // register port: no wait states, word index from address bit 2
    assign pready    = 1'b1;
    assign n_reg_idx = paddr[PADDR_W-1:2];
    assign n_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_low  <= CFG_W'(RESET_LOW);
            r_initial_high <= CFG_W'(RESET_HIGH);
        end else if (n_wr) begin
            unique case (n_reg_idx)
                REG_LOW:  r_initial_low  <= pwdata[CFG_W-1:0];
                REG_HIGH: r_initial_high <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (n_reg_idx)
            REG_LOW:  prdata = PDATA_W'(r_initial_low);
            REG_HIGH: prdata = PDATA_W'(r_initial_high);
            default:  prdata = '0;
        endcase
    end

    // a write also restarts calibration of that bound in every channel
    assign w_cfg.low_we  = n_wr && (n_reg_idx == REG_LOW);
    assign w_cfg.high_we = n_wr && (n_reg_idx == REG_HIGH);
    assign w_cfg.value   = pwdata[CFG_W-1:0];

    assign w_samples = {i_sample_c, i_sample_b, i_sample_a};

    // intake and window tagging
    axnorm_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_samples    (w_samples),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    // calibration, mapping, sums, averages and result register
    axnorm_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_cfg        (w_cfg),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_levels     (w_levels)
    );

    // one divider shared by all channels for the mapping
    axnorm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_level_a = w_levels[0];
    assign o_level_b = w_levels[1];
    assign o_level_c = w_levels[2];

endmodule
`default_nettype wire

// ===== hw/rtl/axnorm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axnorm_div: shared restoring divider
// eight quotient bits, one per cycle, quotient known to be below 256
// ----------------------------------------------------------------------------
module axnorm_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire axnorm_pkg::t_div_req i_req,
    output axnorm_pkg::t_div_rsp      o_rsp
);
    import axnorm_pkg::*;

    logic [DIV_NUM_W-1:0] r_rem;
    t_sample              r_den;
    logic [QUO_W-1:0]     r_quo;
    logic [STEP_W-1:0]    r_step;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] n_trial;
    logic                 n_fit;

    assign n_trial = DIV_NUM_W'(r_den) << r_step;
    assign n_fit   = r_rem >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_quo  <= '0;
                r_step <= STEP_W'(QUO_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_fit) begin
                    r_rem         <= r_rem - n_trial;
                    r_quo[r_step] <= 1'b1;
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/axnorm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axnorm_front: item intake
// counts ticks, tags the item that closes a window, queues items for the back
// ----------------------------------------------------------------------------
module axnorm_front #(
    parameter int WINDOW = axnorm_pkg::WINDOW_DEF
) (
    input  wire                                                 i_clk,
    input  wire                                                 i_rst_n,
    input  wire                                                 i_valid,
    output logic                                                o_ready,
    input  wire axnorm_pkg::t_sample [axnorm_pkg::CHANNELS-1:0] i_samples,
    output axnorm_pkg::t_item                                   o_item,
    output logic                                                o_item_valid,
    input  wire                                                 i_item_pop
);
    import axnorm_pkg::*;

    localparam int TICK_W = $clog2(WINDOW + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_item             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [TICK_W-1:0] r_tick;
    logic              n_push;
    logic              n_pop;
    logic              n_last;

    assign o_ready      = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_item_valid = r_count != '0;
    assign o_item       = r_queue[r_rd_ptr];
    assign n_push       = i_valid && o_ready;
    assign n_pop        = i_item_pop && o_item_valid;
    assign n_last       = r_tick == TICK_W'(WINDOW - 1);

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_queue[r_wr_ptr].samples <= i_samples;
            r_queue[r_wr_ptr].last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_tick   <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_tick   <= n_last ? '0 : r_tick + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/axnorm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axnorm_back: per-channel calibration, mapping, window sums and averages
// sequences the channels through the shared divider, holds the result register
// ----------------------------------------------------------------------------
module axnorm_back #(
    parameter int WINDOW = axnorm_pkg::WINDOW_DEF
) (
    input  wire                                                  i_clk,
    input  wire                                                  i_rst_n,
    input  wire axnorm_pkg::t_item                               i_item,
    input  wire                                                  i_item_valid,
    output logic                                                 o_item_pop,
    input  wire axnorm_pkg::t_cfg_wr                             i_cfg,
    output axnorm_pkg::t_div_req                                 o_div_req,
    input  wire axnorm_pkg::t_div_rsp                            i_div_rsp,
    output logic                                                 o_valid,
    input  wire                                                  i_ready,
    output logic [axnorm_pkg::CHANNELS-1:0][axnorm_pkg::LEVEL_W-1:0] o_levels
);
    import axnorm_pkg::*;

    localparam int SUM_W      = $clog2(LEVEL_TOP * WINDOW + 1) + 1;
    // sum / WINDOW as multiply by rounded-up reciprocal, exact for the sum width
    localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int AVG_MUL_W  = AVG_SHIFT + 1;
    localparam int AVG_MUL    = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL,
        S_BAND,
        S_CLAMP,
        S_DIV,
        S_AVG,
        S_AVGW,
        S_OUT
    } t_state;

    t_state                               r_state;
    logic [CH_W-1:0]                      r_ch;
    t_item                                r_item;
    t_sample                              r_min [CHANNELS];
    t_sample                              r_max [CHANNELS];
    logic signed [SUM_W-1:0]              r_sum [CHANNELS];
    t_sample                              r_lo;
    t_sample                              r_hi;
    t_sample                              r_span;
    logic [SUM_W-1:0]                     r_mag;
    logic                                 r_neg;
    logic [CHANNELS-1:0][LEVEL_W-1:0]     r_avg;
    logic [CHANNELS-1:0][LEVEL_W-1:0]     r_out;
    logic                                 r_out_valid;
    t_div_req                             r_div_req;

    t_sample                 n_raw;
    t_sample                 n_min;
    t_sample                 n_max;
    logic [DZ_PROD_W-1:0]    n_prod;
    t_sample                 n_dz;
    logic                    n_zero;
    t_sample                 n_pos;
    t_sample                 n_diff;
    logic [DIV_NUM_W-1:0]    n_num;
    logic signed [LEVEL_W:0] n_level;
    logic signed [SUM_W-1:0] n_sum_cur;
    logic                    n_neg;
    logic [SUM_W-1:0]        n_mag;
    logic [AVG_PROD_W-1:0]   n_avg_prod;
    t_level                  n_avg_mag;
    t_level                  n_avg;
    logic                    n_last_ch;

    // calibration and band
    assign n_raw  = r_item.samples[r_ch];
    assign n_min  = (n_raw < r_min[r_ch]) ? n_raw : r_min[r_ch];
    assign n_max  = (n_raw > r_max[r_ch]) ? n_raw : r_max[r_ch];
    assign n_prod = DZ_PROD_W'(r_span) * DZ_PROD_W'(DZ_MUL);
    assign n_dz   = SAMPLE_BITS'(n_prod >> DZ_SHIFT);

    // clamp into band and scale
    assign n_zero = r_hi <= r_lo;
    assign n_pos  = (n_raw > r_hi) ? r_hi : ((n_raw < r_lo) ? r_lo : n_raw);
    assign n_diff = n_pos - r_lo;
    assign n_num  = DIV_NUM_W'(n_diff) * DIV_NUM_W'(2 * LEVEL_TOP);

    // inverted level from quotient
    assign n_level = $signed((LEVEL_W + 1)'(LEVEL_TOP)) - $signed({1'b0, i_div_rsp.quo});

    // window average with truncation toward zero
    assign n_sum_cur  = r_sum[r_ch];
    assign n_neg      = n_sum_cur[SUM_W-1];
    assign n_mag      = n_neg ? SUM_W'(-n_sum_cur) : SUM_W'(n_sum_cur);
    assign n_avg_prod = AVG_PROD_W'(r_mag) * AVG_PROD_W'(AVG_MUL);
    assign n_avg_mag  = LEVEL_W'(n_avg_prod >> AVG_SHIFT);
    assign n_avg      = r_neg ? -n_avg_mag : n_avg_mag;

    assign n_last_ch = r_ch == CH_W'(CHANNELS - 1);

    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_div_req  = r_div_req;
    assign o_valid    = r_out_valid;
    assign o_levels   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ch            <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_min[c] <= SAMPLE_BITS'(RESET_LOW);
                r_max[c] <= SAMPLE_BITS'(RESET_HIGH);
                r_sum[c] <= '0;
            end
        end else begin
            r_div_req.start <= 1'b0;
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_ch    <= '0;
                        r_state <= S_CAL;
                    end
                end
                S_CAL: begin
                    r_min[r_ch] <= n_min;
                    r_max[r_ch] <= n_max;
                    r_lo        <= n_min;
                    r_hi        <= n_max;
                    r_span      <= n_max - n_min;
                    r_state     <= S_BAND;
                end
                S_BAND: begin
                    r_lo    <= r_lo + n_dz;
                    r_hi    <= r_hi - n_dz;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (n_zero) begin
                        // empty band maps to zero, sum unchanged
                        if (n_last_ch) begin
                            r_ch    <= '0;
                            r_state <= r_item.last ? S_AVG : S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_CAL;
                        end
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= n_num;
                        r_div_req.den   <= r_hi - r_lo;
                        r_state         <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_sum[r_ch] <= r_sum[r_ch] + SUM_W'(n_level);
                        if (n_last_ch) begin
                            r_ch    <= '0;
                            r_state <= r_item.last ? S_AVG : S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_CAL;
                        end
                    end
                end
                S_AVG: begin
                    r_mag   <= n_mag;
                    r_neg   <= n_neg;
                    r_state <= S_AVGW;
                end
                S_AVGW: begin
                    r_avg[r_ch] <= n_avg;
                    r_sum[r_ch] <= '0;
                    if (n_last_ch) begin
                        r_ch    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_AVG;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_avg;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // bound reload via register port; only while idle, left to the user
            if (i_cfg.low_we) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_min[c] <= SAMPLE_BITS'(i_cfg.value);
                end
            end
            if (i_cfg.high_we) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_max[c] <= SAMPLE_BITS'(i_cfg.value);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== verif/autocal_axis_normalize_average_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autocal_axis_normalize_average_test: self-checking bench of the axis normalizer
// drives sampling ticks and register writes, predicts every window report and
// compares it field-wise against the block, mostly under random idling both sides
// ----------------------------------------------------------------------------
module autocal_axis_normalize_average_test;
    import axnorm_pkg::*;

    localparam int WINDOW        = WINDOW_DEF;
    localparam int SETTLE_CYCLES = 400;    // several ticks of back end work
    localparam int DRAIN_LIMIT   = 5000;   // cycles allowed for pending reports
    localparam int MAX_READING   = (1 << SAMPLE_BITS) - 1;

    // one window report, one level per channel
    typedef struct packed {
        t_level a;
        t_level b;
        t_level c;
    } t_level_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_sample              i_sample_a = '0;
    t_sample              i_sample_b = '0;
    t_sample              i_sample_c = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_level               o_level_a;
    t_level               o_level_b;
    t_level               o_level_c;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    autocal_axis_normalize_average #(
        .WINDOW(WINDOW)
    ) uut (.*);

    // shadow of the block: registers, calibration bounds, running sums
    logic [CFG_W-1:0] low_reg;
    logic [CFG_W-1:0] high_reg;
    t_sample          travel_min [CHANNELS];
    t_sample          travel_max [CHANNELS];
    int               level_sum [CHANNELS];
    int               ticks_in_window;

    t_level_report    pending_levels [$];
    int               fail_count = 0;
    bit               gaps_on = 1'b1;
    bit               sending = 1'b0;

    // travel profile of the current phase
    int               travel_center [CHANNELS];
    int               travel_spread;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void check_level(string name, t_level want, t_level got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: level_%s mismatch, expected %0d, got %0d",
                     $time, name, want, got);
        end
    endfunction

    // result side: random back pressure, check each accepted report
    always @(posedge i_clk) begin
        i_ready <= !gaps_on || ($urandom_range(99) >= 7);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_levels.size() == 0) begin
                fail_count++;
                $display("%0t: report with nothing pending, got %0d %0d %0d",
                         $time, o_level_a, o_level_b, o_level_c);
            end else begin
                t_level_report want;
                want = pending_levels.pop_front();
                check_level("a", want.a, o_level_a);
                check_level("b", want.b, o_level_b);
                check_level("c", want.c, o_level_c);
            end
        end
    end

    // mapped level of one reading; widens the seen travel first
    function automatic int map_reading(int ch, t_sample raw);
        int dz;
        int lo;
        int hi;
        int pos;
        if (raw < travel_min[ch]) travel_min[ch] = raw;
        if (raw > travel_max[ch]) travel_max[ch] = raw;
        dz = (int'(travel_max[ch]) - int'(travel_min[ch])) / DEAD_DIV;
        lo = int'(travel_min[ch]) + dz;
        hi = int'(travel_max[ch]) - dz;
        // empty band after trimming the dead zones
        if (hi <= lo) return 0;
        pos = int'(raw);
        if (pos > hi) pos = hi;
        if (pos < lo) pos = lo;
        return LEVEL_TOP - ((pos - lo) * 2 * LEVEL_TOP) / (hi - lo);
    endfunction

    // one tick into the shadow, queue a report when the window closes
    function automatic void predict_tick(t_sample a, t_sample b, t_sample c);
        t_level_report rep;
        level_sum[0] += map_reading(0, a);
        level_sum[1] += map_reading(1, b);
        level_sum[2] += map_reading(2, c);
        ticks_in_window++;
        if (ticks_in_window == WINDOW) begin
            rep.a = t_level'(level_sum[0] / WINDOW);
            rep.b = t_level'(level_sum[1] / WINDOW);
            rep.c = t_level'(level_sum[2] / WINDOW);
            pending_levels.push_back(rep);
            for (int ch = 0; ch < CHANNELS; ch++) level_sum[ch] = 0;
            ticks_in_window = 0;
        end
    endfunction

    // lower valid once, only if an item was left up
    task automatic drop_valid();
        if (sending) begin
            i_valid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    // one sampling tick, returns in the step of acceptance with valid still up
    task automatic send_tick(input t_sample a, input t_sample b, input t_sample c);
        while (gaps_on && $urandom_range(99) < 7) begin
            drop_valid();
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        sending = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_tick(a, b, c);
    endtask

    // hold the input side until every queued report has come back
    task automatic await_reports();
        int waited;
        waited = 0;
        drop_valid();
        while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_levels.size() != 0) begin
            fail_count += pending_levels.size();
            $display("%0t: %0d reports never arrived", $time, pending_levels.size());
            pending_levels.delete();
        end
    endtask

    // ticks that close no window may still be in the back end
    task automatic settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb transfers chain back to back; release_bus ends the burst
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk above the register width must be dropped
        pwdata  <= (PDATA_W'($urandom) & ~PDATA_W'(MAX_READING)) | PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // a bound write restarts that bound's calibration on every channel
        if (idx == REG_LOW) begin
            low_reg = value;
            for (int ch = 0; ch < CHANNELS; ch++) travel_min[ch] = value;
        end else begin
            high_reg = value;
            for (int ch = 0; ch < CHANNELS; ch++) travel_max[ch] = value;
        end
    endtask

    task automatic read_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== want) begin
            fail_count++;
            $display("%0t: register %0d read mismatch, expected %0d, got %0d",
                     $time, idx, want, prdata[CFG_W-1:0]);
        end
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly readings around the phase's travel, some anywhere, some at the rails
    function automatic t_sample pick_reading(int ch);
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 10) return ($urandom_range(1) != 0) ? t_sample'(MAX_READING) : '0;
        if (roll < 30) return t_sample'($urandom);
        v = travel_center[ch] + int'($urandom_range(2 * travel_spread)) - travel_spread;
        if (v < 0) v = 0;
        if (v > MAX_READING) v = MAX_READING;
        return t_sample'(v);
    endfunction

    // one setting of the bounds followed by a stream of ticks, ends idle
    task automatic run_phase(input int low, input int high, input int write_mask,
                             input int spread, input int n_ticks, input int pause_pct);
        if (write_mask[0]) write_reg(REG_LOW, CFG_W'(low));
        if (write_mask[1]) write_reg(REG_HIGH, CFG_W'(high));
        read_reg(REG_LOW, low_reg);
        read_reg(REG_HIGH, high_reg);
        release_bus();
        travel_spread = spread;
        for (int ch = 0; ch < CHANNELS; ch++) travel_center[ch] = $urandom_range(MAX_READING);
        for (int k = 0; k < n_ticks; k++) begin
            send_tick(pick_reading(0), pick_reading(1), pick_reading(2));
            // sometimes the sender holds off until the window just closed has been reported
            if (ticks_in_window == 0 && k != n_ticks - 1 && $urandom_range(99) < pause_pct)
                await_reports();
        end
        await_reports();
        settle();
    endtask

    // reset bounds, rails, alternating bit patterns, readings at the bounds
    task automatic test_reset_calibration();
        read_reg(REG_LOW, CFG_W'(RESET_LOW));
        read_reg(REG_HIGH, CFG_W'(RESET_HIGH));
        release_bus();
        send_tick(12'd0,    12'd4095, 12'd2048);
        send_tick(12'd4095, 12'd0,    12'd800);
        send_tick(12'd800,  12'd3600, 12'd2200);
        send_tick(12'd3600, 12'd800,  12'd0);
        send_tick(12'hAAA,  12'h555,  12'hFFF);
        send_tick(12'h555,  12'hAAA,  12'h000);
        send_tick(12'd2200, 12'd2200, 12'd2200);
        send_tick(12'd1,    12'd4094, 12'd801);
        send_tick(12'd3599, 12'd3601, 12'd1000);
        send_tick(12'd4095, 12'd4095, 12'd4095);
        await_reports();
        settle();
    endtask

    // both bounds equal: mapped value is zero until a reading widens the band
    task automatic test_empty_band();
        write_reg(REG_LOW, 12'd2000);
        write_reg(REG_HIGH, 12'd2000);
        read_reg(REG_LOW, 12'd2000);
        read_reg(REG_HIGH, 12'd2000);
        release_bus();
        repeat (4) send_tick(12'd2000, 12'd2000, 12'd2000);
        send_tick(12'd2000, 12'd2000, 12'd0);
        send_tick(12'd2000, 12'd4095, 12'd2000);
        send_tick(12'd2001, 12'd1999, 12'd2000);
        send_tick(12'd2000, 12'd0,    12'd4095);
        send_tick(12'd2000, 12'd2000, 12'd2000);
        send_tick(12'd2000, 12'd2000, 12'd2000);
        await_reports();
        settle();
    endtask

    // extreme and inverted bound settings, first one pauses on every window
    task automatic test_bound_reloads();
        run_phase(0,          MAX_READING, 3, 300,  60, 100);
        run_phase(MAX_READING, 0,          3, 500,  60, 10);
        run_phase(MAX_READING, MAX_READING, 3, 0,   60, 10);
        run_phase(0,          0,           3, 50,   60, 10);
        run_phase(RESET_LOW,  RESET_HIGH,  3, 1400, 60, 10);
    endtask

    // random bounds, sometimes only one of them rewritten
    task automatic test_random_travel();
        for (int p = 0; p < 7; p++)
            run_phase($urandom_range(MAX_READING), $urandom_range(MAX_READING),
                      $urandom_range(1, 3), $urandom_range(2000), 100, 10);
    endtask

    // a long stretch with neither side idling
    task automatic test_no_idle_stream();
        gaps_on = 1'b0;
        run_phase($urandom_range(1000), 3000 + $urandom_range(1095), 3, 800, 150, 0);
        gaps_on = 1'b1;
    endtask

    initial begin
        low_reg  = CFG_W'(RESET_LOW);
        high_reg = CFG_W'(RESET_HIGH);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            travel_min[ch] = t_sample'(RESET_LOW);
            travel_max[ch] = t_sample'(RESET_HIGH);
            level_sum[ch]  = 0;
        end
        ticks_in_window = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_calibration();
        test_empty_band();
        test_bound_reloads();
        test_random_travel();
        test_no_idle_stream();

        await_reports();
        settle();
        if (fail_count == 0) begin
            $display("[autocal_axis_normalize_average] OK");
        end else begin
            $display("[autocal_axis_normalize_average] ERROR");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #5ms;
        $display("[autocal_axis_normalize_average] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/axnorm_pkg.sv
hw/rtl/axnorm_div.sv
hw/rtl/axnorm_front.sv
hw/rtl/axnorm_back.sv
hw/rtl/autocal_axis_normalize_average.sv
verif/autocal_axis_normalize_average_test.sv
